@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on rising edge, reset masked
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/rlu_pkg.sv @@
// ----------------------------------------------------------------------------
// rlu_pkg
// shared types and constants of the radix literal parser
// ----------------------------------------------------------------------------
package rlu_pkg;

    localparam int VALUE_BITS = 64;
    localparam int OUT_BITS   = 64;
    localparam int STAT_BITS  = 2;
    localparam int CHAR_BITS  = 8;
    localparam int DIGIT_BITS = 4;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } t_radix;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_BADCHAR  = 2'd1,
        ST_BIGDIGIT = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // what the back end does with one character
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DIGIT = 2'd1,
        ACT_BAD   = 2'd2,
        ACT_BIG   = 2'd3
    } t_act;

    typedef struct packed {
        t_act                  act;
        logic [DIGIT_BITS-1:0] digit;
        t_radix                radix;
        logic                  is_final;
    } t_item;

    // queue push side
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_push;

    // queue pop side
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage

@@ rtl/rlu_char_if.sv @@
// ----------------------------------------------------------------------------
// rlu_char_if
// character channel: one lexeme character per transfer
// ----------------------------------------------------------------------------
interface rlu_char_if;
    logic                          valid;
    logic                          ready;
    logic [rlu_pkg::CHAR_BITS-1:0] char_code;
    logic                          is_final;

    modport source (output valid, output char_code, output is_final, input ready);
    modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

@@ rtl/rlu_result_if.sv @@
// ----------------------------------------------------------------------------
// rlu_result_if
// result channel: parsed value and status per transfer
// ----------------------------------------------------------------------------
interface rlu_result_if;
    logic                          valid;
    logic                          ready;
    logic [rlu_pkg::OUT_BITS-1:0]  value;
    logic [rlu_pkg::STAT_BITS-1:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/rlu_front.sv @@
// ----------------------------------------------------------------------------
// rlu_front
// accepts characters, tracks the prefix, classifies each character
// ----------------------------------------------------------------------------
module rlu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlu_char_if.sink          i_char,
    output rlu_pkg::t_q_push  o_push,
    input  logic              i_push_ready
);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7a;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5a;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_LB = 8'h62;

    t_phase          r_phase, n_phase;
    rlu_pkg::t_radix r_radix, n_radix;

    logic            w_alnum;
    logic [5:0]      w_val;
    logic            w_acc;
    rlu_pkg::t_item  w_item;

    // digit value of the character, letters from ten up
    always_comb begin
        w_alnum = 1'b1;
        w_val   = '0;
        if (i_char.char_code >= CH_0 && i_char.char_code <= CH_9) begin
            w_val = 6'(i_char.char_code - CH_0);
        end else if (i_char.char_code >= CH_LA && i_char.char_code <= CH_LZ) begin
            w_val = 6'(i_char.char_code - CH_LA) + 6'd10;
        end else if (i_char.char_code >= CH_UA && i_char.char_code <= CH_UZ) begin
            w_val = 6'(i_char.char_code - CH_UA) + 6'd10;
        end else begin
            w_alnum = 1'b0;
        end
    end

    function automatic logic [4:0] radix_value(rlu_pkg::t_radix sel);
        case (sel)
            rlu_pkg::RADIX_HEX: radix_value = 5'd16;
            rlu_pkg::RADIX_BIN: radix_value = 5'd2;
            default:            radix_value = 5'd10;
        endcase
    endfunction

    function automatic rlu_pkg::t_act classify(logic alnum, logic [5:0] val,
                                               rlu_pkg::t_radix sel);
        if (!alnum)
            classify = rlu_pkg::ACT_BAD;
        else if (val >= 6'(radix_value(sel)))
            classify = rlu_pkg::ACT_BIG;
        else
            classify = rlu_pkg::ACT_DIGIT;
    endfunction

    assign w_acc = i_char.valid && i_push_ready;

    always_comb begin
        n_phase         = r_phase;
        n_radix         = r_radix;
        w_item.act      = rlu_pkg::ACT_NONE;
        w_item.digit    = w_val[rlu_pkg::DIGIT_BITS-1:0];
        w_item.radix    = rlu_pkg::RADIX_DEC;
        w_item.is_final = i_char.is_final;
        case (r_phase)
            PH_START: begin
                n_radix = rlu_pkg::RADIX_DEC;
                if (i_char.char_code == CH_0) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase    = PH_DIGITS;
                    w_item.act = classify(w_alnum, w_val, rlu_pkg::RADIX_DEC);
                end
            end
            PH_ZERO: begin
                n_phase = PH_DIGITS;
                if (i_char.char_code == CH_LX) begin
                    n_radix = rlu_pkg::RADIX_HEX;
                end else if (i_char.char_code == CH_LB) begin
                    n_radix = rlu_pkg::RADIX_BIN;
                end else begin
                    n_radix    = rlu_pkg::RADIX_DEC;
                    w_item.act = classify(w_alnum, w_val, rlu_pkg::RADIX_DEC);
                end
            end
            default: begin
                w_item.radix = r_radix;
                w_item.act   = classify(w_alnum, w_val, r_radix);
            end
        endcase
        // lexeme done, back to the start state
        if (i_char.is_final) begin
            n_phase = PH_START;
            n_radix = rlu_pkg::RADIX_DEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_radix <= rlu_pkg::RADIX_DEC;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_radix <= n_radix;
        end
    end

    assign i_char.ready = i_push_ready;
    assign o_push.valid = i_char.valid;
    assign o_push.item  = w_item;

endmodule

@@ rtl/rlu_fifo.sv @@
// ----------------------------------------------------------------------------
// rlu_fifo
// two-entry queue of classified characters between front and back
// ----------------------------------------------------------------------------
module rlu_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlu_pkg::t_q_push  i_push,
    output logic              o_push_ready,
    output rlu_pkg::t_q_head  o_head,
    input  logic              i_pop
);

    rlu_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/rlu_back.sv @@
// ----------------------------------------------------------------------------
// rlu_back
// accumulates digits, tracks the first error, registers the result
// ----------------------------------------------------------------------------
module rlu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlu_pkg::t_q_head  i_head,
    output logic              o_pop,
    rlu_result_if.source      o_result
);

    localparam int VB = rlu_pkg::VALUE_BITS;

    logic [VB-1:0]         r_acc, n_acc;
    rlu_pkg::t_status      r_err, n_err;
    logic                  r_out_valid;
    logic [rlu_pkg::OUT_BITS-1:0]  r_out_value;
    rlu_pkg::t_status      r_out_status;

    logic [VB+3:0]         w_prod;
    logic [VB+3:0]         w_sum;
    logic                  w_ovf;
    logic                  w_pop_final;

    // accum times radix as shifts and one add
    always_comb begin
        case (i_head.item.radix)
            rlu_pkg::RADIX_HEX: w_prod = {r_acc, 4'b0000};
            rlu_pkg::RADIX_BIN: w_prod = {3'b000, r_acc, 1'b0};
            default:            w_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
        endcase
        w_sum = w_prod + (VB+4)'(i_head.item.digit);
        w_ovf = |w_sum[VB+3:VB];
    end

    always_comb begin
        n_acc = r_acc;
        n_err = r_err;
        if (r_err == rlu_pkg::ST_OK) begin
            case (i_head.item.act)
                rlu_pkg::ACT_BAD: n_err = rlu_pkg::ST_BADCHAR;
                rlu_pkg::ACT_BIG: n_err = rlu_pkg::ST_BIGDIGIT;
                rlu_pkg::ACT_DIGIT: begin
                    if (w_ovf) n_err = rlu_pkg::ST_OVERFLOW;
                    else       n_acc = w_sum[VB-1:0];
                end
                default: n_acc = r_acc;
            endcase
        end
    end

    assign o_pop = i_head.valid &&
                   (!i_head.item.is_final || !r_out_valid || o_result.ready);
    assign w_pop_final = o_pop && i_head.item.is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_err       <= rlu_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_head.item.is_final) begin
                    r_acc <= '0;
                    r_err <= rlu_pkg::ST_OK;
                end else begin
                    r_acc <= n_acc;
                    r_err <= n_err;
                end
            end
            if (w_pop_final)
                r_out_valid <= 1'b1;
            else if (o_result.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_final) begin
            r_out_value  <= (n_err == rlu_pkg::ST_OK) ?
                            rlu_pkg::OUT_BITS'(n_acc) : '0;
            r_out_status <= n_err;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.value  = r_out_value;
    assign o_result.status = r_out_status;

endmodule

@@ rtl/radix_literal_to_u64_core.sv @@
// ----------------------------------------------------------------------------
// radix_literal_to_u64_core
// streaming parser of one unsigned integer literal per lexeme
// ----------------------------------------------------------------------------
// The block takes a number lexeme one ASCII character per transfer on i_char,
// with is_final set on the last character, and gives one transfer on
// o_result per lexeme: the 64-bit value and a status (ok, bad character,
// digit not below the radix, overflow). A leading "0x" selects hex, a
// leading "0b" binary (lowercase only), anything else decimal; letters count
// from ten up in either case. The first error sticks, value is zero when
// status is not ok. One character is taken every cycle while the queue has
// room; the result is registered when the back end pops the final character.
// The pace is set by the back end, which folds one digit per cycle into the
// accumulator, a final one once o_result is free, with a shift-add multiply
// by the radix plus an exact overflow check on the carry-out bits. A two-entry
// queue lets the character side keep moving while a result waits on o_result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_literal_to_u64_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlu_char_if.sink     i_char,
    rlu_result_if.source o_result
);

    // front end to queue
    rlu_pkg::t_q_push w_push;
    logic             w_push_ready;

    // queue to back end
    rlu_pkg::t_q_head w_head;
    logic             w_pop;

    // prefix tracking and character classification
    rlu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_char),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    // decouples the character stream from the result side
    rlu_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // accumulator, sticky error, result register
    rlu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    // an error result never carries a value
    `ASSERT_IMPL(a_err_zero_value, i_clk, i_rst_n,
        o_result.valid && (o_result.status != rlu_pkg::ST_OK), o_result.value == '0)

    // the back end only consumes what the queue holds
    `ASSERT_IMPL(a_pop_has_item, i_clk, i_rst_n, w_pop, w_head.valid)

    // consuming a final character presents a result on the next cycle
    `ASSERT_NEXT(a_final_gives_result, i_clk, i_rst_n,
        w_pop && w_head.item.is_final, o_result.valid)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the radix literal parser against its own prediction of every lexeme
// ----------------------------------------------------------------------------
// Character lexemes are queued up front: a directed set of edge values first,
// then random lexemes. Most are well-formed hex, binary or decimal numbers,
// some near the top of the 64-bit range. Some carry a bad character or an
// oversized digit, and some are plain noise. A clocked driver feeds the
// characters with random gaps. A clocked monitor updates the parser state
// on every character transfer, stalls the result side at random, and checks
// every result against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_TARGET = 1350;
    localparam int IDLE_LIMIT  = 1000;
    localparam int NOT_DIGIT   = 36;
    localparam bit [63:0] VALUE_MASK = {64{1'b1}} >> (64 - rlu_pkg::VALUE_BITS);

    typedef enum bit [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } t_lex_phase;

    typedef struct packed {
        bit [7:0] code;
        bit       last;
    } t_char_item;

    typedef struct packed {
        bit [63:0]        value;
        rlu_pkg::t_status status;
    } t_literal;

    logic clk;
    logic rst_n;

    rlu_char_if   ch ();
    rlu_result_if res ();

    radix_literal_to_u64_core uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (ch),
        .o_result (res)
    );

    t_char_item pending_chars[$];
    t_literal   literal_results[$];

    // parser state as predicted
    t_lex_phase       lex_phase = PH_START;
    rlu_pkg::t_radix  lex_radix = rlu_pkg::RADIX_DEC;
    bit [63:0]        lex_accum = '0;
    rlu_pkg::t_status lex_err   = rlu_pkg::ST_OK;

    int fail_count = 0;
    int idle_cycles = 0;
    int src_wait = 0;
    int snk_wait = 0;
    bit src_burst = 0;
    bit snk_burst = 0;

    always #2 clk = ~clk;

    // digit value of a character, NOT_DIGIT when not alphanumeric
    function automatic int digit_of(bit [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "z") return int'(c - "a") + 10;
        if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
        return NOT_DIGIT;
    endfunction

    // fold one character into the value, first error sticks
    function automatic void fold_digit(bit [7:0] c);
        int        d;
        bit [63:0] dv;
        bit [63:0] r;
        bit [63:0] lim;
        if (lex_err != rlu_pkg::ST_OK) return;
        d = digit_of(c);
        dv = 64'(d);
        case (lex_radix)
            rlu_pkg::RADIX_HEX: r = 64'd16;
            rlu_pkg::RADIX_BIN: r = 64'd2;
            default:            r = 64'd10;
        endcase
        if (d == NOT_DIGIT) begin
            lex_err = rlu_pkg::ST_BADCHAR;
        end else if (dv >= r) begin
            lex_err = rlu_pkg::ST_BIGDIGIT;
        end else begin
            lim = (VALUE_MASK - dv) / r;
            if (lex_accum > lim) begin
                lex_err = rlu_pkg::ST_OVERFLOW;
            end else begin
                lex_accum = lex_accum * r + dv;
            end
        end
    endfunction

    // advance the parser by one accepted character, queue a result on the last
    function automatic void parse_char(bit [7:0] c, bit last);
        t_literal lit;
        case (lex_phase)
            PH_START: begin
                lex_radix = rlu_pkg::RADIX_DEC;
                lex_accum = '0;
                lex_err = rlu_pkg::ST_OK;
                if (c == "0") begin
                    lex_phase = PH_ZERO;
                end else begin
                    lex_phase = PH_DIGITS;
                    fold_digit(c);
                end
            end
            PH_ZERO: begin
                lex_phase = PH_DIGITS;
                if (c == "x") begin
                    lex_radix = rlu_pkg::RADIX_HEX;
                end else if (c == "b") begin
                    lex_radix = rlu_pkg::RADIX_BIN;
                end else begin
                    lex_radix = rlu_pkg::RADIX_DEC;
                    fold_digit(c);
                end
            end
            default: begin
                fold_digit(c);
            end
        endcase
        if (last) begin
            lit.value = (lex_err == rlu_pkg::ST_OK) ? (lex_accum & VALUE_MASK) : '0;
            lit.status = lex_err;
            literal_results.insert(literal_results.size(), lit);
            lex_phase = PH_START;
            lex_radix = rlu_pkg::RADIX_DEC;
            lex_accum = '0;
            lex_err = rlu_pkg::ST_OK;
        end
    endfunction

    function automatic void push_bytes(bit [7:0] b[$]);
        t_char_item it;
        foreach (b[i]) begin
            it.code = b[i];
            it.last = (i == b.size() - 1);
            pending_chars.insert(pending_chars.size(), it);
        end
    endfunction

    function automatic void push_text(string s);
        bit [7:0] b[$];
        foreach (s[i]) b.insert(b.size(), s[i]);
        push_bytes(b);
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // mostly well-formed numbers, a share corrupted, a few of pure noise
    function automatic void add_random_lexeme();
        bit [7:0]        lex[$];
        bit [7:0]        c;
        int              kind;
        int              n;
        int              d;
        int              r;
        int              pos;
        rlu_pkg::t_radix sel;
        string           head;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) lex.insert(lex.size(), 8'($urandom_range(0, 255)));
        end else begin
            sel = rlu_pkg::t_radix'($urandom_range(0, 2));
            r = (sel == rlu_pkg::RADIX_HEX) ? 16 : (sel == rlu_pkg::RADIX_BIN) ? 2 : 10;
            if (sel == rlu_pkg::RADIX_HEX) begin
                lex.insert(lex.size(), "0");
                lex.insert(lex.size(), "x");
            end else if (sel == rlu_pkg::RADIX_BIN) begin
                lex.insert(lex.size(), "0");
                lex.insert(lex.size(), "b");
            end
            if (kind < 20) begin
                // right at the top of the 64-bit range
                if (sel == rlu_pkg::RADIX_HEX) begin
                    repeat (15) lex.insert(lex.size(), $urandom_range(0, 1) ? "f" : "F");
                end else if (sel == rlu_pkg::RADIX_BIN) begin
                    repeat (63) lex.insert(lex.size(), "1");
                end else begin
                    head = "1844674407370955161";
                    foreach (head[i]) lex.insert(lex.size(), head[i]);
                end
                n = (sel == rlu_pkg::RADIX_DEC) ? 1 : $urandom_range(1, 2);
            end else if (kind < 35) begin
                n = (r == 16) ? $urandom_range(14, 17) :
                    (r == 2)  ? $urandom_range(60, 66) : $urandom_range(18, 21);
            end else begin
                n = $urandom_range((sel == rlu_pkg::RADIX_DEC) ? 1 : 0, 8);
            end
            repeat (n) begin
                d = $urandom_range(0, r - 1);
                if (d < 10) begin
                    c = 8'("0" + d);
                end else if ($urandom_range(0, 1)) begin
                    c = 8'("a" + d - 10);
                end else begin
                    c = 8'("A" + d - 10);
                end
                lex.insert(lex.size(), c);
            end
            if (kind >= 88) begin
                // bad character or digit too large, somewhere in the lexeme
                pos = $urandom_range(0, lex.size() - 1);
                if ($urandom_range(0, 1)) begin
                    do c = 8'($urandom_range(0, 255)); while (digit_of(c) != NOT_DIGIT);
                end else begin
                    do c = 8'($urandom_range(0, 255));
                    while (digit_of(c) == NOT_DIGIT || digit_of(c) < r);
                end
                lex[pos] = c;
            end
        end
        push_bytes(lex);
    endfunction

    // character driver
    always @(posedge clk) begin : drive_p
        t_char_item nxt;
        if (!rst_n) begin
            ch.valid <= 1'b0;
            ch.char_code <= '0;
            ch.is_final <= 1'b0;
            src_wait <= 0;
        end else if (!ch.valid || ch.ready) begin
            if (src_wait != 0) begin
                ch.valid <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (pending_chars.size() != 0) begin
                nxt = pending_chars.pop_front();
                ch.valid <= 1'b1;
                ch.char_code <= nxt.code;
                ch.is_final <= nxt.last;
                if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
                src_wait <= draw_wait(src_burst);
            end else begin
                ch.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on character transfers, check result transfers
    always @(posedge clk) begin : watch_p
        t_literal want;
        int       n;
        if (!rst_n) begin
            res.ready <= 1'b0;
            snk_wait <= 0;
        end else begin
            if (ch.valid && ch.ready) parse_char(ch.char_code, ch.is_final);
            if (res.valid && res.ready) begin
                if (literal_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: value %h status %0d",
                                 res.value, res.status);
                end else begin
                    want = literal_results.pop_front();
                    if (res.value !== want.value || res.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                                     want.value, want.status, res.value, res.status);
                    end
                end
                if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
                n = draw_wait(snk_burst);
                res.ready <= (n == 0);
                snk_wait <= n;
            end else if (!res.ready) begin
                if (snk_wait <= 1) begin
                    res.ready <= 1'b1;
                    snk_wait <= 0;
                end else begin
                    snk_wait <= snk_wait - 1;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((ch.valid && ch.ready) || (res.valid && res.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        string    s;
        bit [7:0] raw[$];
        clk = 1'b0;
        rst_n = 1'b0;
        ch.valid = 1'b0;
        ch.char_code = '0;
        ch.is_final = 1'b0;
        res.ready = 1'b0;

        // lone zero, bare prefixes, a single digit, zero then another digit
        push_text("0");
        push_text("0x");
        push_text("0b");
        push_text("7");
        push_text("05");
        push_text("00x1");
        // uppercase prefix letters are decimal digits that are too large
        push_text("0X1");
        push_text("0B1");
        // limits of the 64-bit range in each radix
        push_text("0xffffffffffffffff");
        push_text("0x10000000000000000");
        push_text("18446744073709551615");
        push_text("18446744073709551616");
        push_text("99999999999999999999");
        s = "0b";
        repeat (64) s = {s, "1"};
        push_text(s);
        push_text({s, "1"});
        // mixed case letters, digit too large, bad characters
        push_text("0xAbCdEf");
        push_text("0b1010");
        push_text("0b102");
        push_text("0xg1");
        push_text("9z");
        push_text("Zz");
        push_text("12-3");
        push_text("0xFF_FF");
        raw.insert(raw.size(), 8'h00);
        push_bytes(raw);
        raw.delete();
        raw.insert(raw.size(), "1");
        raw.insert(raw.size(), 8'hff);
        push_bytes(raw);

        while (pending_chars.size() < ITEM_TARGET) add_random_lexeme();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || ch.valid || literal_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && literal_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rlu_pkg.sv
rtl/rlu_char_if.sv
rtl/rlu_result_if.sv
rtl/rlu_front.sv
rtl/rlu_fifo.sv
rtl/rlu_back.sv
rtl/radix_literal_to_u64_core.sv
dv/testbench.sv
